// ===== hdl/jsesc_pkg.sv =====
package jsesc_pkg;

   // Byte classes of UTF-8 and JSON
   localparam logic [7:0] LEAD_MIN   = 8'hC2;
   localparam logic [7:0] LEAD_END   = 8'hF5;
   localparam logic [7:0] LEAD3_MIN  = 8'hE0;
   localparam logic [7:0] LEAD4_MIN  = 8'hF0;
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_VAL   = 8'h80;
   localparam logic [7:0] CTRL_END   = 8'h20;
   localparam logic [7:0] CHR_QUOTE  = 8'h22;
   localparam logic [7:0] CHR_BSLASH = 8'h5C;
   localparam logic [7:0] CHR_U      = 8'h75;
   localparam logic [7:0] CHR_ZERO   = 8'h30;
   localparam logic [7:0] CHR_F      = 8'h66;
   localparam logic [7:0] CHR_D      = 8'h64;

   // Byte counts of the escape units
   localparam logic [2:0] LEN_RAW   = 3'd1;
   localparam logic [2:0] LEN_SHORT = 3'd2;
   localparam logic [2:0] LEN_UESC  = 3'd6;

   // Main unit of a job, sent after its replacement escapes
   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_RAW,
      KIND_SHORT,
      KIND_UHEX,
      KIND_SEQ
   } kind_type;

   // One queued job: n_repl times \ufffd, then the main unit
   typedef struct packed {
      logic            last;
      logic [2:0]      n_repl;
      kind_type        kind;
      logic [7:0]      chr;
      logic [2:0]      seq_len;
      logic [2:0][7:0] pend;
   } job_type;

   function automatic logic [2:0] lead_len(input logic [7:0] c);
      logic [2:0] len;
      if (c < LEAD3_MIN) begin
         len = 3'd2;
      end else if (c < LEAD4_MIN) begin
         len = 3'd3;
      end else begin
         len = 3'd4;
      end
      return len;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      logic [7:0] d;
      if (n < 4'd10) begin
         d = 8'h30 + {4'd0, n};
      end else begin
         d = 8'h57 + {4'd0, n};
      end
      return d;
   endfunction

   // Second byte of a short escape, zero when the byte has none
   function automatic logic [7:0] short_char(input logic [7:0] c);
      logic [7:0] s;
      case (c)
         8'h22:   s = 8'h22;
         8'h5C:   s = 8'h5C;
         8'h08:   s = 8'h62;
         8'h0C:   s = 8'h66;
         8'h0A:   s = 8'h6E;
         8'h0D:   s = 8'h72;
         8'h09:   s = 8'h74;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

   // \ufffd, byte by byte
   function automatic logic [7:0] repl_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = CHR_BSLASH;
         3'd1:    b = CHR_U;
         3'd2:    b = CHR_F;
         3'd3:    b = CHR_F;
         3'd4:    b = CHR_F;
         default: b = CHR_D;
      endcase
      return b;
   endfunction

   // \u00xx, byte by byte
   function automatic logic [7:0] uhex_byte(input logic [7:0] c, input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = CHR_BSLASH;
         3'd1:    b = CHR_U;
         3'd2:    b = CHR_ZERO;
         3'd3:    b = CHR_ZERO;
         3'd4:    b = hex_digit(c[7:4]);
         default: b = hex_digit(c[3:0]);
      endcase
      return b;
   endfunction

endpackage

// ===== hdl/jsesc_front.sv =====
module jsesc_front import jsesc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   output logic       push,
   output job_type    job
);

   logic [2:0][7:0] pend_ff;
   logic [1:0]      pc_ff, pc_in;
   logic [2:0]      el_ff, el_in;
   logic            wr_en;
   logic [1:0]      wr_idx;
   logic            cont;
   logic            has_out;

   assign cont = (in_byte & CONT_MASK) == CONT_VAL;

   // Classify the byte and work out the pending sequence
   always_comb begin
      job.last    = in_last;
      job.n_repl  = 3'd0;
      job.kind    = KIND_NONE;
      job.chr     = in_byte;
      job.seq_len = 3'd0;
      job.pend    = pend_ff;
      pc_in       = pc_ff;
      el_in       = el_ff;
      wr_en       = 1'b0;
      wr_idx      = pc_ff;
      if (pc_ff != 2'd0 && cont) begin
         if ({1'b0, pc_ff} + 3'd1 >= el_ff) begin
            job.kind    = KIND_SEQ;
            job.seq_len = {1'b0, pc_ff} + 3'd1;
            pc_in       = 2'd0;
            el_in       = 3'd0;
         end else begin
            wr_en = 1'b1;
            pc_in = pc_ff + 2'd1;
         end
      end else begin
         // flush whatever was held, then treat the byte as fresh
         job.n_repl = {1'b0, pc_ff};
         pc_in      = 2'd0;
         el_in      = 3'd0;
         if (in_byte[7]) begin
            if (in_byte >= LEAD_MIN && in_byte < LEAD_END) begin
               wr_en  = 1'b1;
               wr_idx = 2'd0;
               pc_in  = 2'd1;
               el_in  = lead_len(in_byte);
            end else begin
               job.n_repl = job.n_repl + 3'd1;
            end
         end else if (in_byte >= CTRL_END && in_byte != CHR_QUOTE &&
                      in_byte != CHR_BSLASH) begin
            job.kind = KIND_RAW;
         end else if (short_char(in_byte) != 8'h00) begin
            job.kind = KIND_SHORT;
         end else begin
            job.kind = KIND_UHEX;
         end
      end
      // string end flushes an open sequence
      if (in_last) begin
         job.n_repl = job.n_repl + {1'b0, pc_in};
         pc_in      = 2'd0;
         el_in      = 3'd0;
      end
   end

   assign has_out = job.n_repl != 3'd0 || job.kind != KIND_NONE;
   assign push    = accept && has_out;

   // Sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= 2'd0;
         el_ff <= 3'd0;
      end else if (accept) begin
         pc_ff <= pc_in;
         el_ff <= el_in;
      end
   end

   // Held bytes of an open sequence
   always_ff @(posedge clock) begin
      if (accept && wr_en) begin
         pend_ff[wr_idx] <= in_byte;
      end
   end

   a_pend_short: assert property (@(posedge clock) disable iff (reset)
      pc_ff != 2'd0 |-> {1'b0, pc_ff} < el_ff)
      else $error("held count not below sequence length");

   a_idle_len: assert property (@(posedge clock) disable iff (reset)
      pc_ff == 2'd0 |-> el_ff == 3'd0)
      else $error("sequence length left without held bytes");

endmodule

// ===== hdl/jsesc_queue.sv =====
module jsesc_queue import jsesc_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    push_ready,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign push_ready = cnt_ff != CNT_W'(DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head_job   = mem_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Job storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== hdl/jsesc_back.sv =====
module jsesc_back import jsesc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] capacity,
   input  logic        head_valid,
   input  job_type     head_job,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser
);

   logic [2:0]  rep_cnt_ff, rep_cnt_in;
   logic [2:0]  byte_cnt_ff, byte_cnt_in;
   logic [16:0] written_ff, written_in;
   logic        ovf_ff, ovf_in;
   logic        out_valid_ff;
   logic [7:0]  out_byte_ff;
   logic        out_run_ff, out_str_ff, out_ovf_ff;

   logic        in_repl;
   logic [2:0]  main_len, unit_len;
   logic [7:0]  main_byte, cur_byte;
   logic        unit_done, job_done, fire, first, exceed, ovf_now;
   logic [16:0] written_sum;

   assign in_repl = rep_cnt_ff < head_job.n_repl;

   // Main unit byte and length
   always_comb begin
      case (head_job.kind)
         KIND_RAW: begin
            main_len  = LEN_RAW;
            main_byte = head_job.chr;
         end
         KIND_SHORT: begin
            main_len  = LEN_SHORT;
            main_byte = (byte_cnt_ff == 3'd0) ? CHR_BSLASH : short_char(head_job.chr);
         end
         KIND_UHEX: begin
            main_len  = LEN_UESC;
            main_byte = uhex_byte(head_job.chr, byte_cnt_ff);
         end
         KIND_SEQ: begin
            main_len  = head_job.seq_len;
            main_byte = (byte_cnt_ff == head_job.seq_len - 3'd1) ? head_job.chr
                                                               : head_job.pend[byte_cnt_ff[1:0]];
         end
         default: begin
            main_len  = LEN_UESC;
            main_byte = repl_byte(byte_cnt_ff);
         end
      endcase
   end

   assign unit_len = in_repl ? LEN_UESC : main_len;
   assign cur_byte = in_repl ? repl_byte(byte_cnt_ff) : main_byte;
   assign unit_done = byte_cnt_ff == unit_len - 3'd1;
   assign job_done  = unit_done && (!in_repl ||
                      (rep_cnt_ff + 3'd1 == head_job.n_repl && head_job.kind == KIND_NONE));
   assign fire      = head_valid && (!out_valid_ff || rsp_tready);
   assign pop       = fire && job_done;

   // Capacity check at the first byte of each unit
   assign first       = byte_cnt_ff == 3'd0;
   assign written_sum = written_ff + 17'(unit_len);
   assign exceed      = ovf_ff || written_sum > {1'b0, capacity};
   assign ovf_now     = first ? exceed : ovf_ff;

   always_comb begin
      rep_cnt_in  = rep_cnt_ff;
      byte_cnt_in = byte_cnt_ff;
      written_in  = written_ff;
      ovf_in      = ovf_ff;
      if (fire) begin
         if (first) begin
            if (exceed) begin
               ovf_in = 1'b1;
            end else begin
               written_in = written_sum;
            end
         end
         if (unit_done) begin
            byte_cnt_in = 3'd0;
            rep_cnt_in  = in_repl ? rep_cnt_ff + 3'd1 : rep_cnt_ff;
         end else begin
            byte_cnt_in = byte_cnt_ff + 3'd1;
         end
         if (job_done) begin
            rep_cnt_in = 3'd0;
            if (head_job.last) begin
               written_in = 17'd0;
               ovf_in     = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rep_cnt_ff  <= 3'd0;
         byte_cnt_ff <= 3'd0;
         written_ff  <= 17'd0;
         ovf_ff      <= 1'b0;
      end else begin
         rep_cnt_ff  <= rep_cnt_in;
         byte_cnt_ff <= byte_cnt_in;
         written_ff  <= written_in;
         ovf_ff      <= ovf_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_byte_ff <= cur_byte;
         out_run_ff  <= job_done;
         out_str_ff  <= job_done && head_job.last;
         out_ovf_ff  <= ovf_now;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_run_ff;
   assign rsp_tuser  = {out_ovf_ff, out_str_ff};

   a_rep_bound: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> rep_cnt_ff <= head_job.n_repl)
      else $error("replacement count past job");

   a_byte_bound: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> byte_cnt_ff < unit_len)
      else $error("byte index past unit");

   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      ovf_ff && !(pop && head_job.last) |=> ovf_ff)
      else $error("overflow cleared inside a string");

endmodule

// ===== hdl/json_string_escape_utf8_sanitize.sv =====
// An accepted byte is held in the sequence state or as a job in a queue slot, then its
// escaped bytes pass through the output register to rsp.
// Throughput: one input byte per cycle while each byte gives one output byte and
// the queue has room; the back end sends one output byte per cycle while rsp_tready
// is high, so an expanding byte holds it back; QUEUE_DEPTH jobs buffer the front end.
// Reset: synchronous, active high; clears the queue, sequence state, byte count,
// overflow flag, and sets the capacity register to 65535.
module json_string_escape_utf8_sanitize import jsesc_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // last_of_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // run_end
   output logic [1:0]  rsp_tuser,   // [0] string_end, [1] overflow
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [15:0] csr_tdata    // [15:0] output_capacity
);

   logic        accept;
   logic        push, push_ready, pop, head_valid;
   job_type     push_job, head_job;
   logic [15:0] capacity_ff;

   // Capacity register
   assign csr_tready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= 16'hFFFF;
      end else if (csr_tvalid && csr_tready) begin
         capacity_ff <= csr_tdata;
      end
   end

   assign req_tready = push_ready;
   assign accept     = req_tvalid && req_tready;

   jsesc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_tdata),
      .in_last (req_tlast),
      .push    (push),
      .job     (push_job)
   );

   jsesc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   jsesc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .capacity   (capacity_ff),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import jsesc_pkg::*;

   localparam int  SETTLE_CYCLES = 24;
   localparam int  LONG_STALL    = 400;
   localparam int  WATCHDOG_NS   = 10_000_000;

   // Control bytes with short escapes
   localparam logic [7:0] CTL_BS  = 8'h08;
   localparam logic [7:0] CTL_TAB = 8'h09;
   localparam logic [7:0] CTL_LF  = 8'h0A;
   localparam logic [7:0] CTL_FF  = 8'h0C;
   localparam logic [7:0] CTL_CR  = 8'h0D;

   localparam logic [127:0]    HEX_DIGITS = "0123456789abcdef";
   // \ufffd, first byte in the low lane
   localparam logic [5:0][7:0] REPL_ESC   = {CHR_D, CHR_F, CHR_F, CHR_F, CHR_U, CHR_BSLASH};

   typedef struct packed {
      logic [7:0] chr;
      logic       last;
   } raw_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       string_end;
      logic       overflow;
   } esc_byte_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;
   logic        csr_tvalid = 1'b0;
   logic        csr_tready;
   logic [15:0] csr_tdata  = 16'h0000;

   json_string_escape_utf8_sanitize i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Stimulus and expected output
   raw_item_type raw_bytes_q[$];
   esc_byte_type escaped_due[$];
   esc_byte_type step_out[$];

   int src_gap_max  = 0;
   int sink_gap_max = 0;
   int src_wait     = 0;
   int sink_wait    = 0;
   int mismatches   = 0;
   int rsp_seen     = 0;
   bit hold_req     = 1'b0;
   logic rsp_hold   = 1'b0;

   // Escaper state as the block should hold it
   logic [7:0] held_seq[3];
   int         held_cnt  = 0;
   int         seq_len   = 0;
   int         out_count = 0;
   bit         cap_hit   = 1'b0;
   int         capacity  = 65535;

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      return HEX_DIGITS[8 * (15 - n) +: 8];
   endfunction

   // One output unit: charged against capacity as a whole
   task automatic put_unit(input logic [5:0][7:0] u, input int n);
      esc_byte_type r;
      if (cap_hit || out_count + n > capacity) begin
         cap_hit = 1'b1;
      end else begin
         out_count += n;
      end
      for (int i = 0; i < n; i++) begin
         r.out_byte   = u[i];
         r.run_end    = 1'b0;
         r.string_end = 1'b0;
         r.overflow   = cap_hit;
         step_out.push_back(r);
      end
   endtask

   task automatic flush_held();
      for (int i = 0; i < held_cnt; i++) begin
         put_unit(REPL_ESC, 6);
      end
      held_cnt = 0;
      seq_len  = 0;
   endtask

   // Byte seen outside an open sequence
   task automatic escape_fresh(input logic [7:0] c);
      logic [7:0] sc;
      if (c >= CONT_VAL) begin
         if (c >= LEAD_MIN && c < LEAD_END) begin
            held_seq[0] = c;
            held_cnt    = 1;
            seq_len     = (c < LEAD3_MIN) ? 2 : (c < LEAD4_MIN) ? 3 : 4;
         end else begin
            put_unit(REPL_ESC, 6);
         end
      end else if (c >= CTRL_END && c != CHR_QUOTE && c != CHR_BSLASH) begin
         put_unit({40'd0, c}, 1);
      end else begin
         case (c)
            CHR_QUOTE:  sc = CHR_QUOTE;
            CHR_BSLASH: sc = CHR_BSLASH;
            CTL_BS:     sc = "b";
            CTL_FF:     sc = "f";
            CTL_LF:     sc = "n";
            CTL_CR:     sc = "r";
            CTL_TAB:    sc = "t";
            default:    sc = 8'h00;
         endcase
         if (sc != 8'h00) begin
            put_unit({32'd0, sc, CHR_BSLASH}, 2);
         end else begin
            put_unit({hex_char(c[3:0]), hex_char(c[7:4]), CHR_ZERO, CHR_ZERO,
                      CHR_U, CHR_BSLASH}, 6);
         end
      end
   endtask

   // Predict the escaped bytes of one accepted item
   task automatic escape_byte(input logic [7:0] c, input logic last);
      logic [5:0][7:0] seq;
      bit done;
      done = 1'b0;
      seq  = '0;
      step_out.delete();
      if (held_cnt > 0) begin
         if ((c & CONT_MASK) == CONT_VAL) begin
            if (held_cnt + 1 >= seq_len) begin
               for (int i = 0; i < held_cnt; i++) begin
                  seq[i] = held_seq[i];
               end
               seq[held_cnt] = c;
               put_unit(seq, held_cnt + 1);
               held_cnt = 0;
               seq_len  = 0;
            end else begin
               held_seq[held_cnt] = c;
               held_cnt++;
            end
            done = 1'b1;
         end else begin
            flush_held();
         end
      end
      if (!done) begin
         escape_fresh(c);
      end
      if (last) begin
         flush_held();
         out_count = 0;
         cap_hit   = 1'b0;
      end
      if (step_out.size() > 0) begin
         step_out[step_out.size() - 1].run_end    = 1'b1;
         step_out[step_out.size() - 1].string_end = last;
      end
      foreach (step_out[i]) begin
         escaped_due.push_back(step_out[i]);
      end
   endtask

   task automatic report_miss(input string what, input logic [7:0] got, input logic [7:0] want);
      mismatches++;
      if (mismatches <= 40) begin
         $display("mismatch at output item %0d: %s got %h want %h", rsp_seen, what, got, want);
      end
   endtask

   // Input driver: one item per handshake, random gap after each
   always @(posedge clock) begin : drive_proc
      logic         take;
      raw_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'h00;
         req_tlast  <= 1'b0;
         src_wait   <= 0;
      end else begin
         take = req_tvalid && req_tready;
         if (take) begin
            escape_byte(req_tdata, req_tlast);
         end
         if (!req_tvalid || take) begin
            if (src_wait > 0) begin
               src_wait   <= src_wait - 1;
               req_tvalid <= 1'b0;
            end else if (raw_bytes_q.size() > 0) begin
               nxt = raw_bytes_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.chr;
               req_tlast  <= nxt.last;
               src_wait   <= $urandom_range(0, src_gap_max);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Output monitor: checks each item, then stalls at random
   always @(posedge clock) begin : sink_proc
      esc_byte_type want;
      int           w;
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_wait  <= 0;
      end else begin
         w = sink_wait;
         if (rsp_tvalid && rsp_tready) begin
            if (escaped_due.size() == 0) begin
               report_miss("unexpected item", rsp_tdata, 8'h00);
            end else begin
               want = escaped_due.pop_front();
               if (rsp_tdata !== want.out_byte) begin
                  report_miss("out_byte", rsp_tdata, want.out_byte);
               end
               if (rsp_tlast !== want.run_end) begin
                  report_miss("run_end", {7'd0, rsp_tlast}, {7'd0, want.run_end});
               end
               if (rsp_tuser[0] !== want.string_end) begin
                  report_miss("string_end", {7'd0, rsp_tuser[0]}, {7'd0, want.string_end});
               end
               if (rsp_tuser[1] !== want.overflow) begin
                  report_miss("overflow", {7'd0, rsp_tuser[1]}, {7'd0, want.overflow});
               end
            end
            rsp_seen++;
            w = $urandom_range(0, sink_gap_max);
         end else if (!rsp_tready && w > 0) begin
            w = w - 1;
         end
         sink_wait  <= w;
         rsp_tready <= !rsp_hold && (w == 0);
      end
   end

   // Long receiver hold-off while the sender keeps offering
   initial begin
      wait (hold_req);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (LONG_STALL) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #(WATCHDOG_NS);
      $display("tb NOT OK");
      $finish;
   end

   task automatic push_raw(input logic [7:0] c, input logic last);
      raw_bytes_q.push_back('{chr: c, last: last});
   endtask

   task automatic write_capacity(input logic [15:0] v);
      @(posedge clock);
      csr_tvalid <= 1'b1;
      csr_tdata  <= v;
      do @(posedge clock); while (!csr_tready);
      csr_tvalid <= 1'b0;
      capacity = v;
   endtask

   task automatic wait_idle();
      while (raw_bytes_q.size() != 0 || req_tvalid || escaped_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly text and well-formed sequences, some broken ones and noise
   task automatic add_random_string(inout int added);
      logic [7:0] s[$];
      int ntok;
      int pick;
      int len;
      int ncont;
      ntok = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
      repeat (ntok) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            s.push_back(8'($urandom_range(CTRL_END, CONT_VAL - 1)));
         end else if (pick < 52) begin
            case ($urandom_range(0, 2))
               0:       s.push_back(CHR_QUOTE);
               1:       s.push_back(CHR_BSLASH);
               default: s.push_back(8'($urandom_range(0, CTRL_END - 1)));
            endcase
         end else if (pick < 90) begin
            len = $urandom_range(2, 4);
            case (len)
               2:       s.push_back(8'($urandom_range(LEAD_MIN, LEAD3_MIN - 1)));
               3:       s.push_back(8'($urandom_range(LEAD3_MIN, LEAD4_MIN - 1)));
               default: s.push_back(8'($urandom_range(LEAD4_MIN, LEAD_END - 1)));
            endcase
            // well-formed unless cut short
            ncont = (pick < 80) ? len - 1 : $urandom_range(0, len - 2);
            repeat (ncont) s.push_back(8'($urandom_range(CONT_VAL, CONT_MASK - 1)));
         end else begin
            s.push_back(8'($urandom_range(0, 255)));
         end
      end
      foreach (s[i]) begin
         push_raw(s[i], i == s.size() - 1);
      end
      added += s.size();
   endtask

   task automatic run_phase(input logic [15:0] cap, input int n_items, input int src_max,
                            input int sink_max, input bit long_stall);
      int added;
      added = 0;
      write_capacity(cap);
      src_gap_max  = src_max;
      sink_gap_max = sink_max;
      while (added < n_items) begin
         add_random_string(added);
      end
      if (long_stall) begin
         hold_req = 1'b1;
      end
      wait_idle();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: controls, escapes, ASCII boundary bytes
      push_raw(8'h00, 1'b0);
      push_raw(8'h1F, 1'b0);
      push_raw(8'h7F, 1'b0);
      push_raw(8'h20, 1'b0);
      push_raw(CHR_QUOTE, 1'b0);
      push_raw(CHR_BSLASH, 1'b0);
      push_raw(CTL_BS, 1'b0);
      push_raw(CTL_FF, 1'b0);
      push_raw(CTL_LF, 1'b0);
      push_raw(CTL_CR, 1'b0);
      push_raw(CTL_TAB, 1'b1);
      // bad lead bytes
      push_raw(8'h80, 1'b0);
      push_raw(8'hC1, 1'b0);
      push_raw(8'hF5, 1'b0);
      push_raw(8'hFF, 1'b1);
      // shortest and longest sequences at the lead extremes
      push_raw(8'hC2, 1'b0);
      push_raw(8'hBF, 1'b0);
      push_raw(8'hF4, 1'b0);
      push_raw(8'h8F, 1'b0);
      push_raw(8'hBF, 1'b0);
      push_raw(8'hBF, 1'b1);
      // broken sequence, then a lead left open at string end
      push_raw(8'hE0, 1'b0);
      push_raw(8'h80, 1'b0);
      push_raw(8'h41, 1'b0);
      push_raw(8'hF0, 1'b1);
      wait_idle();

      // Zero capacity: every unit overflows
      write_capacity(16'h0000);
      push_raw(8'h41, 1'b0);
      push_raw(8'hFF, 1'b1);
      wait_idle();

      // Random phases over several capacities and idle patterns
      run_phase(16'hFFFF, 70, 0, 0, 1'b0);
      run_phase(16'h0000, 50, 14, 14, 1'b0);
      run_phase(16'd12, 70, 0, 4, 1'b1);
      run_phase(16'($urandom_range(1, 48)), 70, 4, 0, 1'b0);
      run_phase(16'($urandom_range(256, 65534)), 80, 14, 4, 1'b0);
      run_phase(16'hFFFF, 70, 14, 14, 1'b0);

      if (mismatches == 0 && escaped_due.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
